>>> hdl/ascc_pkg.sv
`default_nettype none

package ascc_pkg;

  // Default sizing
  localparam int DEF_MAX_STATES = 16;
  localparam int DEF_NUM_REGS   = 10;

  // Fixed field widths
  localparam int CFG_W         = 5;
  localparam int OUT_REGS_W    = 10;
  localparam int WORDS_PER_REG = 10;

  // Request codes
  localparam logic [1:0] REQ_WORD  = 2'd0;
  localparam logic [1:0] REQ_CONC  = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // Word selects within one register entry
  localparam logic [3:0] W_UMIN   = 4'd0;
  localparam logic [3:0] W_UMAX   = 4'd1;
  localparam logic [3:0] W_SMIN   = 4'd2;
  localparam logic [3:0] W_SMAX   = 4'd3;
  localparam logic [3:0] W_U32MIN = 4'd4;
  localparam logic [3:0] W_U32MAX = 4'd5;
  localparam logic [3:0] W_S32MIN = 4'd6;
  localparam logic [3:0] W_S32MAX = 4'd7;
  localparam logic [3:0] W_TVAL   = 4'd8;
  localparam logic [3:0] W_TMASK  = 4'd9;
  localparam logic [3:0] W_FLAGS  = 4'd10;

  typedef logic [WORDS_PER_REG-1:0][63:0] word_set_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;       // start a check: clear scan pointer and accumulators
    logic issue;       // read the next stored state
    logic load;        // accept a non-check transaction
    logic emit_check;  // drive the check result
  } ascc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic last;
    logic found;
    logic pipe_idle;
  } ascc_sts_t;

endpackage

`default_nettype wire

>>> hdl/ascc_ram.sv
`default_nettype none

module ascc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/ascc_ctrl.sv
`default_nettype none

module ascc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  ascc_pkg::ascc_sts_t sts,
  output ascc_pkg::ascc_cmd_t cmd,
  output logic              busy
);

  import ascc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_CHECK) begin
            cmd.clear = 1'b1;
            state_nxt = sts.n_zero ? S_DRAIN : S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last || sts.found) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for reads in flight to retire
        if (sts.pipe_idle) begin
          cmd.emit_check = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/ascc_dpath.sv
`default_nettype none

module ascc_dpath #(
  parameter int MAX_STATES = ascc_pkg::DEF_MAX_STATES,
  parameter int NUM_REGS   = ascc_pkg::DEF_NUM_REGS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ascc_pkg::ascc_cmd_t               cmd,
  output ascc_pkg::ascc_sts_t               sts,
  input  logic [1:0]                        req_type,
  input  logic [3:0]                        state_index,
  input  logic [3:0]                        reg_index,
  input  logic [3:0]                        word_select,
  input  logic [63:0]                       word_value,
  input  logic                              cfg_we,
  input  logic [ascc_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  output logic                              out_is_check_result,
  output logic                              out_violation,
  output logic [ascc_pkg::OUT_REGS_W-1:0]   out_failing_regs
);

  import ascc_pkg::*;

  localparam int AW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CNT_W = $clog2(MAX_STATES + 1);
  localparam int SAT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SW    = AW + 4;
  localparam int OHX_W = (NUM_REGS > OUT_REGS_W) ? NUM_REGS : OUT_REGS_W;

  function automatic logic reg_fail(input logic [1:0] f, input word_set_t w,
                                    input logic [63:0] v);
    logic bad;
    logic [31:0] v32;
    v32 = v[31:0];
    bad = 1'b0;
    if (f[0]) begin
      if (v < w[W_UMIN] || v > w[W_UMAX]) bad = 1'b1;
      if ($signed(v) < $signed(w[W_SMIN]) || $signed(w[W_SMAX]) < $signed(v)) bad = 1'b1;
      if (v32 < w[W_U32MIN][31:0] || v32 > w[W_U32MAX][31:0]) bad = 1'b1;
      if ($signed(v32) < $signed(w[W_S32MIN][31:0]) ||
          $signed(w[W_S32MAX][31:0]) < $signed(v32)) bad = 1'b1;
      if ((v & ~w[W_TMASK]) != w[W_TVAL]) bad = 1'b1;
    end else begin
      bad = f[1] && (v == 64'd0);
    end
    return bad;
  endfunction

  logic [CFG_W-1:0]      num_states_r;
  logic [SAT_W-1:0]      n_sat;
  logic [CNT_W-1:0]      cnt_r;
  logic [SW-1:0]         si_ext;
  logic                  si_ok;
  logic                  ri_ok;
  logic                  wr_word;
  logic                  wr_flag;
  logic [63:0]           conc_r [NUM_REGS];
  word_set_t             wrd [NUM_REGS];
  logic [1:0]            flg [NUM_REGS];
  logic [NUM_REGS-1:0]   fail_vec;
  logic [NUM_REGS-1:0]   fail_r;
  logic [NUM_REGS-1:0]   first_oh;
  logic [OHX_W-1:0]      first_ohx;
  logic                  v1_r;
  logic                  v2_r;
  logic                  found_r;
  logic [OUT_REGS_W-1:0] mask_r;

  // Write decode
  assign si_ext  = SW'(state_index);
  assign si_ok   = si_ext < SW'(MAX_STATES);
  assign ri_ok   = {1'b0, reg_index} < 5'(NUM_REGS);
  assign wr_word = cmd.load && (req_type == REQ_WORD) && si_ok && ri_ok &&
                   (word_select < 4'(WORDS_PER_REG));
  assign wr_flag = cmd.load && (req_type == REQ_WORD) && si_ok && ri_ok &&
                   (word_select == W_FLAGS);

  // One RAM per word of each register entry, addressed by state
  for (genvar r = 0; r < NUM_REGS; r++) begin : g_reg
    for (genvar w = 0; w < WORDS_PER_REG; w++) begin : g_word
      ascc_ram #(.WIDTH(64), .DEPTH(MAX_STATES)) u_word (
        .clk   (clk),
        .we    (wr_word && (reg_index == 4'(r)) && (word_select == 4'(w))),
        .waddr (si_ext[AW-1:0]),
        .wdata (word_value),
        .re    (cmd.issue),
        .raddr (cnt_r[AW-1:0]),
        .rdata (wrd[r][w])
      );
    end
    ascc_ram #(.WIDTH(2), .DEPTH(MAX_STATES)) u_flag (
      .clk   (clk),
      .we    (wr_flag && (reg_index == 4'(r))),
      .waddr (si_ext[AW-1:0]),
      .wdata (word_value[1:0]),
      .re    (cmd.issue),
      .raddr (cnt_r[AW-1:0]),
      .rdata (flg[r])
    );

    always_ff @(posedge clk) begin
      if (cmd.load && (req_type == REQ_CONC) && (reg_index == 4'(r))) begin
        conc_r[r] <= word_value;
      end
    end

    always_comb begin
      fail_vec[r] = reg_fail(flg[r], wrd[r], conc_r[r]);
    end
  end

  // Scan bound, saturated to table depth
  always_comb begin
    if (SAT_W'(num_states_r) > SAT_W'(MAX_STATES)) begin
      n_sat = SAT_W'(MAX_STATES);
    end else begin
      n_sat = SAT_W'(num_states_r);
    end
  end

  assign first_oh  = fail_r & (~fail_r + NUM_REGS'(1));
  assign first_ohx = OHX_W'(first_oh);

  always_ff @(posedge clk) begin
    fail_r <= fail_vec;
    if (!rst_n) begin
      num_states_r <= '0;
      cnt_r        <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      found_r      <= 1'b0;
      mask_r       <= '0;
    end else begin
      if (cfg_we) begin
        num_states_r <= cfg_wdata;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.clear) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
        mask_r  <= '0;
      end else begin
        if (cmd.issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        // drop results of states read after a match
        if (v2_r && !found_r) begin
          if (fail_r == '0) begin
            found_r <= 1'b1;
          end else begin
            mask_r <= mask_r | first_ohx[OUT_REGS_W-1:0];
          end
        end
      end
    end
  end

  assign sts.n_zero    = (n_sat == '0);
  assign sts.last      = ((SAT_W'(cnt_r) + SAT_W'(1)) == n_sat);
  assign sts.found     = found_r;
  assign sts.pipe_idle = !v1_r && !v2_r;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.load || cmd.emit_check;
    end
    out_is_check_result <= cmd.emit_check;
    out_violation       <= cmd.emit_check && !found_r;
    out_failing_regs    <= (cmd.emit_check && !found_r) ? mask_r : '0;
  end

endmodule

`default_nettype wire

>>> hdl/abstract_state_containment_checker.sv
`default_nettype none

// Abstract state containment checker. Load transactions (req_type 0 writes one
// word or the flags of a stored register entry, req_type 1 writes one concrete
// register) leave busy low and the zero result appears on the next cycle. A check
// transaction (req_type 2) scans the first n stored states, where n is num_states
// capped at MAX_STATES, one state per cycle, testing all registers of a state in
// parallel; it keeps busy high until its result is emitted, stops issuing reads
// once a match retires, and issues no reads when n is zero. The state tables feed
// a three-stage read/test/accumulate pipe, which is drained before the result.
// Every transaction yields one result, shown for exactly one cycle with
// out_valid; the receiver cannot stall, so capture it when out_valid is high.
// Write cfg_wdata with cfg_we only while busy is low and no result is pending.
// A check must only touch stored entries and concrete registers written earlier.

module abstract_state_containment_checker #(
  parameter int MAX_STATES = ascc_pkg::DEF_MAX_STATES,
  parameter int NUM_REGS   = ascc_pkg::DEF_NUM_REGS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic [3:0]                      in_state_index,
  input  logic [3:0]                      in_reg_index,
  input  logic [3:0]                      in_word_select,
  input  logic [63:0]                     in_word_value,
  input  logic                            cfg_we,
  input  logic [ascc_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic                            out_is_check_result,
  output logic                            out_violation,
  output logic [ascc_pkg::OUT_REGS_W-1:0] out_failing_regs
);

  import ascc_pkg::*;

  ascc_cmd_t cmd;
  ascc_sts_t sts;

  // Sequence loads and the state scan
  ascc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Hold the state tables, concrete registers and the test pipe
  ascc_dpath #(
    .MAX_STATES (MAX_STATES),
    .NUM_REGS   (NUM_REGS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .req_type            (in_req_type),
    .state_index         (in_state_index),
    .reg_index           (in_reg_index),
    .word_select         (in_word_select),
    .word_value          (in_word_value),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_is_check_result (out_is_check_result),
    .out_violation       (out_violation),
    .out_failing_regs    (out_failing_regs)
  );

  // A check ends by presenting its result as busy drops
  a_check_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_is_check_result)
    else $error("check finished without a check result");

  // A load transaction answers on the next cycle with a non-check result
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != REQ_CHECK)) |=>
      out_valid && !out_is_check_result && !out_violation)
    else $error("load transaction result missing or malformed");

  // A passing check carries no failing registers
  a_pass_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_violation) |-> (out_failing_regs == '0))
    else $error("failing register mask set without a violation");

  // No scan reads are issued outside a check
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> busy && !out_valid)
    else $error("state read issued while idle or with result pending");

endmodule

`default_nettype wire
